// ----- rtl/array_table_engine_assert.svh -----
// Assertion macros used by the array table engine sequencer RTL.
`ifndef ARRAY_TABLE_ENGINE_ASSERT_SVH
`define ARRAY_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ATE_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ATE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ate_pkg.sv -----
// Types and constants of the array table engine.
`default_nettype none

package ate_pkg;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_SEARCH = 3'd2;
    localparam logic [2:0] ACT_GET    = 3'd3;
    localparam logic [2:0] ACT_SET    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0]  REG_CAPACITY   = 2'd0;
    localparam logic [6:0]  CAPACITY_RESET = 7'd64;
    localparam logic [31:0] DATA_GET_FAIL  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        rd_en;
        logic [6:0]  rd_idx;
        logic        wr_en;
        logic [6:0]  wr_idx;
        logic [31:0] wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/ate_cfg.sv -----
// APB-style configuration register file of the array table engine.
`default_nettype none

module ate_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [6:0]       capacity
);

    logic [6:0] capacity_reg;
    logic [6:0] capacity_next;
    logic       wr_hit;

    assign pready   = 1'b1;
    assign wr_hit   = psel && penable && pwrite && (paddr == ate_pkg::REG_CAPACITY);
    assign capacity = capacity_reg;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_hit)
        begin
            capacity_next = pwdata[6:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ate_pkg::REG_CAPACITY)
        begin
            prdata = {25'd0, capacity_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= ate_pkg::CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ate_mem.sv -----
// Entry memory: one write port, one read port, registered read data.
`default_nettype none

module ate_mem #(
    parameter int DEPTH = 64
) (
    input  wire logic             clk,
    input  wire ate_pkg::mem_req_t req,
    output logic [31:0]           rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[AW'(req.wr_idx)] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[AW'(req.rd_idx)];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ate_seq.sv -----
// Request sequencer: walks the entry memory and holds count, sum and the result register.
`default_nettype none

module ate_seq #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [6:0]         capacity,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         action,
    input  wire logic [6:0]         position,
    input  wire logic signed [31:0] operand,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      data_out,
    output logic [5:0]              found_at,
    output logic [1:0]              status,
    output logic [6:0]              count,
    output logic signed [31:0]      total,
    output ate_pkg::mem_req_t       mem_req,
    input  wire logic [31:0]        rd_data
);

    localparam int         LIM_MAX_I = (DEPTH > 127) ? 127 : DEPTH;
    localparam logic [6:0] LIM_MAX   = 7'(LIM_MAX_I);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [6:0]  fill_reg, fill_next;
    logic [31:0] sum_reg, sum_next;
    logic        out_valid_reg, out_valid_next;

    logic [2:0]  op_reg, op_next;
    logic [6:0]  pos_reg, pos_next;
    logic [31:0] val_reg, val_next;
    logic [6:0]  cur_reg, cur_next;
    logic [31:0] res_data_reg, res_data_next;
    logic [5:0]  res_found_reg, res_found_next;
    logic [1:0]  res_status_reg, res_status_next;

    logic [31:0] data_out_reg;
    logic [5:0]  found_at_reg;
    logic [1:0]  status_reg;
    logic [6:0]  count_reg;
    logic [31:0] total_reg;

    logic [6:0]  limit;
    logic [6:0]  fill_m1;
    logic [6:0]  cur_p1;
    logic [6:0]  cur_m1;
    logic        out_free;
    logic        load_out;
    logic        accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign found_at  = found_at_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign total     = total_reg;

    assign limit    = (capacity < LIM_MAX) ? capacity : LIM_MAX;
    assign fill_m1  = fill_reg - 7'd1;
    assign cur_p1   = cur_reg + 7'd1;
    assign cur_m1   = cur_reg - 7'd1;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == S_FIN) && out_free;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        sum_next        = sum_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        cur_next        = cur_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        mem_req         = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = action;
                    pos_next        = position;
                    val_next        = operand;
                    res_data_next   = '0;
                    res_found_next  = '0;
                    res_status_next = ate_pkg::ST_OK;
                    state_next      = S_FIN;
                    case (action)
                        ate_pkg::ACT_INSERT:
                        begin
                            if (position > fill_reg)
                            begin
                                res_status_next = ate_pkg::ST_RANGE;
                            end
                            else if (fill_reg >= limit)
                            begin
                                res_status_next = ate_pkg::ST_FULL;
                            end
                            else if (position == fill_reg)
                            begin
                                // append: nothing to shift
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_idx  = position;
                                mem_req.wr_data = operand;
                                fill_next       = fill_reg + 7'd1;
                                sum_next        = sum_reg + operand;
                            end
                            else
                            begin
                                mem_req.rd_en  = 1'b1;
                                mem_req.rd_idx = fill_m1;
                                cur_next       = fill_m1;
                                state_next     = S_WALK;
                            end
                        end
                        ate_pkg::ACT_DELETE:
                        begin
                            if (position >= fill_reg)
                            begin
                                res_status_next = ate_pkg::ST_RANGE;
                            end
                            else
                            begin
                                mem_req.rd_en  = 1'b1;
                                mem_req.rd_idx = position;
                                cur_next       = position;
                                state_next     = S_WALK;
                            end
                        end
                        ate_pkg::ACT_SEARCH:
                        begin
                            if (fill_reg == 7'd0)
                            begin
                                res_status_next = ate_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                mem_req.rd_en  = 1'b1;
                                mem_req.rd_idx = 7'd0;
                                cur_next       = 7'd0;
                                state_next     = S_WALK;
                            end
                        end
                        ate_pkg::ACT_GET, ate_pkg::ACT_SET:
                        begin
                            if (position >= fill_reg)
                            begin
                                res_status_next = ate_pkg::ST_RANGE;
                                if (action == ate_pkg::ACT_GET)
                                begin
                                    res_data_next = ate_pkg::DATA_GET_FAIL;
                                end
                            end
                            else
                            begin
                                mem_req.rd_en  = 1'b1;
                                mem_req.rd_idx = position;
                                state_next     = S_LAST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                case (op_reg)
                    ate_pkg::ACT_INSERT:
                    begin
                        // move entry cur up by one, fetch the one below
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_idx  = cur_p1;
                        mem_req.wr_data = rd_data;
                        if (cur_reg > pos_reg)
                        begin
                            mem_req.rd_en  = 1'b1;
                            mem_req.rd_idx = cur_m1;
                            cur_next       = cur_m1;
                        end
                        else
                        begin
                            state_next = S_LAST;
                        end
                    end
                    ate_pkg::ACT_DELETE:
                    begin
                        if (cur_reg == pos_reg)
                        begin
                            res_data_next = rd_data;
                            sum_next      = sum_reg - rd_data;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_idx  = cur_m1;
                            mem_req.wr_data = rd_data;
                        end
                        if (cur_p1 < fill_reg)
                        begin
                            mem_req.rd_en  = 1'b1;
                            mem_req.rd_idx = cur_p1;
                            cur_next       = cur_p1;
                        end
                        else
                        begin
                            fill_next  = fill_m1;
                            state_next = S_FIN;
                        end
                    end
                    ate_pkg::ACT_SEARCH:
                    begin
                        if (rd_data == val_reg)
                        begin
                            res_found_next  = cur_reg[5:0];
                            res_status_next = ate_pkg::ST_OK;
                            state_next      = S_FIN;
                        end
                        else if (cur_p1 < fill_reg)
                        begin
                            mem_req.rd_en  = 1'b1;
                            mem_req.rd_idx = cur_p1;
                            cur_next       = cur_p1;
                        end
                        else
                        begin
                            res_status_next = ate_pkg::ST_NOTFOUND;
                            state_next      = S_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_LAST:
            begin
                case (op_reg)
                    ate_pkg::ACT_INSERT:
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_idx  = pos_reg;
                        mem_req.wr_data = val_reg;
                        fill_next       = fill_reg + 7'd1;
                        sum_next        = sum_reg + val_reg;
                    end
                    ate_pkg::ACT_GET:
                    begin
                        res_data_next = rd_data;
                    end
                    ate_pkg::ACT_SET:
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_idx  = pos_reg;
                        mem_req.wr_data = val_reg;
                        sum_next        = sum_reg - rd_data + val_reg;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            data_out_reg <= res_data_reg;
            found_at_reg <= res_found_reg;
            status_reg   <= res_status_reg;
            count_reg    <= fill_reg;
            total_reg    <= sum_reg;
        end
    end

    `include "array_table_engine_assert.svh"

    `ATE_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= LIM_MAX, "fill beyond table limit")
    `ATE_ASSERT_SAME(a_rw_apart, mem_req.rd_en && mem_req.wr_en,
        mem_req.rd_idx != mem_req.wr_idx, "read and write hit the same entry")
    `ATE_ASSERT_SAME(a_wr_packed, mem_req.wr_en, mem_req.wr_idx <= fill_reg,
        "write beyond the packed region")
    `ATE_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE,
        "sequencer idle right after a transaction")
    `ATE_ASSERT_NEXT(a_result_out, load_out, out_valid_reg,
        "finished result not presented")

endmodule

`default_nettype wire

// ----- rtl/array_table_engine.sv -----
// Top level of the array table engine: bounded signed-word list with shift insert/delete.
//
// Input channel: in_valid / in_stall carry action, position and operand; one
// transaction is taken when in_valid is high and in_stall is low. Output
// channel: out_valid / out_stall carry data_out, found_at, status, count and
// total, exactly one result transaction per input transaction, in order.
// Timing is set by the walk over the single-read, single-write entry memory.
// Get and set read the entry at position; insert shifts the entries from the top
// down to position one up, then writes the new one; delete takes out the entry at
// position and shifts those above it one down; search reads from entry 0 up to the
// first match or the end; an append, a rejected request and an unknown action go
// straight to the finish. A new transaction is taken the cycle after the result is
// moved into the output register, not while the last one is worked. The output
// register holds one result; while out_stall is high the result holds and the next
// transaction is taken and worked, then waits. Reset clears the count, the running
// sum, the output valid and sets capacity to 64; the entry memory is not cleared
// and is read only below the count. The user writes capacity through the APB port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module array_table_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         action,
    input  wire logic [6:0]         position,
    input  wire logic signed [31:0] operand,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      data_out,
    output logic [5:0]              found_at,
    output logic [1:0]              status,
    output logic [6:0]              count,
    output logic signed [31:0]      total
);

    logic [6:0]        capacity;
    ate_pkg::mem_req_t mem_req;
    logic [31:0]       rd_data;

    ate_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    ate_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    ate_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .position  (position),
        .operand   (operand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .found_at  (found_at),
        .status    (status),
        .count     (count),
        .total     (total),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

endmodule

`default_nettype wire

// ----- test/array_table_engine_tb.sv -----
// Self-checking testbench for array_table_engine: directed, capacity, backpressure, random.
`default_nettype none

module array_table_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_LAST = 3'd7;

    typedef struct packed {
        logic signed [31:0] data;
        logic [5:0]         found;
        logic [1:0]         status;
        logic [6:0]         count;
        logic signed [31:0] total;
    } table_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic [6:0]         position;
    logic signed [31:0] operand;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] data_out;
    logic [5:0]         found_at;
    logic [1:0]         status;
    logic [6:0]         count;
    logic signed [31:0] total;

    logic signed [31:0] table_shadow [TABLE_DEPTH];
    int                 shadow_fill;
    logic signed [31:0] shadow_sum;
    int                 shadow_capacity;

    table_result_t      pending_results[$];
    int                 mismatch_count;
    int                 send_gap_pct;
    int                 recv_gap_pct;
    longint             cycle_count;
    longint             hold_until;

    array_table_engine #(.DEPTH(TABLE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .position  (position),
        .operand   (operand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .found_at  (found_at),
        .status    (status),
        .count     (count),
        .total     (total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output side: random stall, plus a long hold-off window on request.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (!rst_n)
                out_stall <= 1'b0;
            else if (cycle_count < hold_until)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
        end
    end

    function automatic table_result_t table_apply(logic [2:0] act, logic [6:0] pos,
                                                  logic signed [31:0] opd);
        table_result_t r;
        int            i;
        int            lim;
        bit            hit;
        r = '0;
        lim = (shadow_capacity < TABLE_DEPTH) ? shadow_capacity : TABLE_DEPTH;
        case (act)
            ate_pkg::ACT_INSERT:
            begin
                if (int'(pos) > shadow_fill)
                    r.status = ate_pkg::ST_RANGE;
                else if (shadow_fill >= lim)
                    r.status = ate_pkg::ST_FULL;
                else
                begin
                    for (i = shadow_fill; i > int'(pos); i--)
                        table_shadow[i] = table_shadow[i - 1];
                    table_shadow[pos] = opd;
                    shadow_fill++;
                    shadow_sum += opd;
                end
            end
            ate_pkg::ACT_DELETE:
            begin
                if (int'(pos) >= shadow_fill)
                    r.status = ate_pkg::ST_RANGE;
                else
                begin
                    r.data = table_shadow[pos];
                    for (i = pos; i + 1 < shadow_fill; i++)
                        table_shadow[i] = table_shadow[i + 1];
                    shadow_fill--;
                    shadow_sum -= r.data;
                end
            end
            ate_pkg::ACT_SEARCH:
            begin
                r.status = ate_pkg::ST_NOTFOUND;
                hit = 1'b0;
                for (i = 0; i < shadow_fill; i++)
                begin
                    if (!hit && table_shadow[i] == opd)
                    begin
                        hit = 1'b1;
                        r.found = 6'(i);
                        r.status = ate_pkg::ST_OK;
                    end
                end
            end
            ate_pkg::ACT_GET:
            begin
                if (int'(pos) >= shadow_fill)
                begin
                    r.status = ate_pkg::ST_RANGE;
                    r.data = ate_pkg::DATA_GET_FAIL;
                end
                else
                    r.data = table_shadow[pos];
            end
            ate_pkg::ACT_SET:
            begin
                if (int'(pos) >= shadow_fill)
                    r.status = ate_pkg::ST_RANGE;
                else
                begin
                    shadow_sum = shadow_sum - table_shadow[pos] + opd;
                    table_shadow[pos] = opd;
                end
            end
            default: ;
        endcase
        r.count = 7'(shadow_fill);
        r.total = shadow_sum;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none actual data_out %0h",
                         $time, data_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("data_out", want.data, data_out);
                compare_field("found_at", 32'(want.found), 32'(found_at));
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("count", 32'(want.count), 32'(count));
                compare_field("total", want.total, total);
            end
        end
    end

    task automatic send_request(logic [2:0] act, logic [6:0] pos, logic signed [31:0] opd);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        position <= pos;
        operand  <= opd;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(table_apply(act, pos, opd));
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(int cap_value);
        wait_for_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(4 * ate_pkg::REG_CAPACITY);
        pwdata  <= 32'(cap_value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_capacity = cap_value;
    endtask

    function automatic logic signed [31:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        if (sel < 40)
            return 32'($urandom_range(0, 15));
        return $urandom;
    endfunction

    task automatic send_random_request();
        int                 sel;
        int                 lim;
        int                 ins_cut;
        logic [2:0]         act;
        logic [6:0]         pos;
        logic signed [31:0] opd;
        lim = (shadow_capacity < TABLE_DEPTH) ? shadow_capacity : TABLE_DEPTH;
        ins_cut = (shadow_fill * 2 < lim) ? 45 : 25;
        sel = $urandom_range(0, 99);
        if (sel < ins_cut)
            act = ate_pkg::ACT_INSERT;
        else if (sel < 60)
            act = ate_pkg::ACT_DELETE;
        else if (sel < 73)
            act = ate_pkg::ACT_SEARCH;
        else if (sel < 86)
            act = ate_pkg::ACT_GET;
        else if (sel < 97)
            act = ate_pkg::ACT_SET;
        else
            act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        if ($urandom_range(0, 99) < 80 && (act == ate_pkg::ACT_INSERT || shadow_fill > 0))
            pos = (act == ate_pkg::ACT_INSERT) ? 7'($urandom_range(0, shadow_fill))
                                               : 7'($urandom_range(0, shadow_fill - 1));
        else
            pos = 7'($urandom_range(0, 127));
        if (act == ate_pkg::ACT_SEARCH && shadow_fill > 0 && $urandom_range(0, 1))
            opd = table_shadow[$urandom_range(0, shadow_fill - 1)];
        else
            opd = pick_operand();
        send_request(act, pos, opd);
    endtask

    task automatic test_directed_edges();
        send_request(ate_pkg::ACT_GET, 7'd0, 32'sd5);
        send_request(ate_pkg::ACT_DELETE, 7'd0, 32'sd5);
        send_request(ate_pkg::ACT_SET, 7'd0, 32'sd5);
        send_request(ate_pkg::ACT_SEARCH, 7'd0, 32'sd0);
        send_request(ate_pkg::ACT_INSERT, 7'd1, 32'sd9);
        send_request(ate_pkg::ACT_INSERT, 7'd127, 32'sd9);
        send_request(ate_pkg::ACT_INSERT, 7'd0, 32'sh7FFF_FFFF);
        send_request(ate_pkg::ACT_INSERT, 7'd1, 32'sh8000_0000);
        send_request(ate_pkg::ACT_INSERT, 7'd1, -32'sd1);
        send_request(ate_pkg::ACT_INSERT, 7'd0, 32'sd0);
        send_request(ate_pkg::ACT_GET, 7'd3, 32'sd0);
        send_request(ate_pkg::ACT_GET, 7'd127, 32'sd0);
        send_request(ate_pkg::ACT_GET, 7'd4, 32'sd0);
        send_request(ate_pkg::ACT_SEARCH, 7'd0, -32'sd1);
        send_request(ate_pkg::ACT_INSERT, 7'd2, 32'sh7FFF_FFFF);
        send_request(ate_pkg::ACT_SEARCH, 7'd127, 32'sh7FFF_FFFF);
        send_request(ate_pkg::ACT_SET, 7'd0, 32'sh1234_5678);
        send_request(ate_pkg::ACT_SET, 7'd127, 32'sh1234_5678);
        send_request(ate_pkg::ACT_DELETE, 7'd4, 32'sd0);
        send_request(ate_pkg::ACT_DELETE, 7'd127, 32'sd0);
        send_request(ate_pkg::ACT_DELETE, 7'd0, 32'sd0);
        send_request(ACT_UNUSED_FIRST, 7'd127, -32'sd1);
        send_request(ACT_UNUSED_MID, 7'd0, 32'sh8000_0000);
        send_request(ACT_UNUSED_LAST, 7'd64, 32'sh7FFF_FFFF);
    endtask

    task automatic test_capacity_limits();
        int i;
        // Capacity dropped under the current fill: held entries stay usable.
        write_capacity(1);
        send_request(ate_pkg::ACT_INSERT, 7'd0, 32'sd77);
        send_request(ate_pkg::ACT_INSERT, 7'd127, 32'sd77);
        send_request(ate_pkg::ACT_SEARCH, 7'd0, table_shadow[shadow_fill - 1]);
        send_request(ate_pkg::ACT_SET, 7'(shadow_fill - 1), 32'sd42);
        send_request(ate_pkg::ACT_GET, 7'(shadow_fill - 1), 32'sd0);
        while (shadow_fill > 0)
            send_request(ate_pkg::ACT_DELETE, 7'($urandom_range(0, shadow_fill - 1)), 32'sd0);
        send_request(ate_pkg::ACT_INSERT, 7'd0, 32'sd3);
        send_request(ate_pkg::ACT_INSERT, 7'd1, 32'sd4);
        write_capacity(TABLE_DEPTH);
        for (i = 0; i < 70 && shadow_fill < TABLE_DEPTH; i++)
            send_request(ate_pkg::ACT_INSERT, 7'($urandom_range(0, shadow_fill)),
                         pick_operand());
        send_request(ate_pkg::ACT_INSERT, 7'd64, 32'sd1);
        send_request(ate_pkg::ACT_INSERT, 7'd0, 32'sd1);
        send_request(ate_pkg::ACT_INSERT, 7'd127, 32'sd1);
        send_request(ate_pkg::ACT_SEARCH, 7'd0, 32'sh5A5A_1234);
        send_request(ate_pkg::ACT_SEARCH, 7'd0, table_shadow[TABLE_DEPTH - 1]);
        send_request(ate_pkg::ACT_GET, 7'd63, 32'sd0);
        send_request(ate_pkg::ACT_SET, 7'd63, 32'sh8000_0000);
        send_request(ate_pkg::ACT_DELETE, 7'd0, 32'sd0);
        send_request(ate_pkg::ACT_DELETE, 7'd62, 32'sd0);
        wait_for_idle();
    endtask

    task automatic test_output_backpressure();
        int i;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_until = cycle_count + 400;
        for (i = 0; i < 40; i++)
            send_random_request();
        wait_for_idle();
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct);
        int blk;
        int i;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        for (blk = 0; blk < 3; blk++)
        begin
            case (blk)
                0: write_capacity($urandom_range(1, 2) == 1 ? 1 : TABLE_DEPTH);
                1: write_capacity($urandom_range(1, TABLE_DEPTH));
                default: write_capacity($urandom_range(TABLE_DEPTH / 2, TABLE_DEPTH));
            endcase
            for (i = 0; i < 140; i++)
                send_random_request();
        end
        wait_for_idle();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        action   <= ate_pkg::ACT_INSERT;
        position <= '0;
        operand  <= '0;
        mismatch_count = 0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        cycle_count = 0;
        hold_until = 0;
        shadow_fill = 0;
        shadow_sum = '0;
        shadow_capacity = int'(ate_pkg::CAPACITY_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 36;
        recv_gap_pct = 54;
        test_directed_edges();
        test_capacity_limits();
        test_output_backpressure();
        test_random_traffic(36, 54);
        test_random_traffic(54, 36);
        test_random_traffic(0, 0);

        wait_for_idle();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
